[sv/red_pkg.sv]
package red_pkg;

  // request kinds carried from the parser to the cluster stage
  localparam logic [1:0] KIND_RUN = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;

  // configuration register indexes
  localparam logic CFG_PART_START = 1'b0;
  localparam logic CFG_SEC_PER_CLU = 1'b1;

  localparam logic [7:0] LEN_NIBBLE_MASK = 8'h0F;
  localparam logic [7:0] OFF_NIBBLE_MASK = 8'hF0;
  localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

  localparam logic [47:0] PART_START_RESET = 48'd0;
  localparam logic [7:0] SEC_PER_CLU_RESET = 8'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] count;
    logic [63:0] offset;
  } red_req_t;

  typedef struct packed {
    logic     valid;
    red_req_t req;
  } red_push_t;

endpackage

[sv/red_byte_if.sv]
interface red_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_byte;

  modport source (output valid, output run_byte, input ready);
  modport sink (input valid, input run_byte, output ready);
endinterface

[sv/red_result_if.sv]
interface red_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] run_start_cluster;
  logic [63:0] run_cluster_count;
  logic [63:0] run_first_virtual;
  logic [63:0] run_first_sector;
  logic        list_end;
  logic        bad_header;

  modport source (
    output valid, output run_start_cluster, output run_cluster_count,
    output run_first_virtual, output run_first_sector, output list_end,
    output bad_header, input ready
  );
  modport sink (
    input valid, input run_start_cluster, input run_cluster_count,
    input run_first_virtual, input run_first_sector, input list_end,
    input bad_header, output ready
  );
endinterface

[sv/runlist_extent_decoder.sv]
// channel   dir  handshake      payload
// in_ch     in   valid/ready    run_byte[7:0], one run list byte per request
// out_ch    out  valid/ready    start, count, first virtual, first sector, list_end, bad_header
// cfg_*     in   cfg_we         cfg_index selects register, cfg_wdata[47:0]
//
// one byte per cycle is taken while the request queue has room
// the completing byte enters the queue; the request then passes the cluster adder register
// and the sector mult / output register in that order, and a stalled out_ch can hold either
// the cluster adder keeps one request per cycle while out_ch is ready, so the back end also runs at one per cycle
// reset (rst_n low, synchronous) clears the parser, queue, pipeline and running sums
// a stalled out_ch fills the pipeline then the queue, after which in_ch.ready drops
module runlist_extent_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  red_byte_if.sink     in_ch,
  red_result_if.source out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [47:0]  cfg_wdata
);

  // configuration registers
  logic [47:0] part_start_r;
  logic [7:0]  sec_per_clu_r;

  // front to queue
  red_pkg::red_push_t push;
  logic               q_full;

  // queue to back
  logic               q_valid;
  red_pkg::red_req_t  q_data;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_start_r  <= red_pkg::PART_START_RESET;
      sec_per_clu_r <= red_pkg::SEC_PER_CLU_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        red_pkg::CFG_PART_START:  part_start_r  <= cfg_wdata;
        red_pkg::CFG_SEC_PER_CLU: sec_per_clu_r <= cfg_wdata[7:0];
      endcase
    end
  end

  // byte parser: headers, length and offset bytes, sign extension
  red_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  // short request queue so the parser and the cluster stage stall apart
  red_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (q_full),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (q_pop)
  );

  // running cluster sums, sector calculation and output register
  red_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .pop         (q_pop),
    .part_start  (part_start_r),
    .sec_per_clu (sec_per_clu_r),
    .out_ch      (out_ch)
  );

endmodule

[sv/red_front.sv]
module red_front (
  input  logic                clk,
  input  logic                rst_n,
  red_byte_if.sink            in_ch,
  input  logic                q_full,
  output red_pkg::red_push_t  push
);

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_OFF = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  len_bytes_r, len_bytes_nxt;
  logic [3:0]  off_bytes_r, off_bytes_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] len_acc_r, len_acc_nxt;
  logic [63:0] off_acc_r, off_acc_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [3:0]  lo, hi;
  logic [3:0]  pos_inc;
  logic [63:0] byte_shifted;

  // sign extension of the offset from its byte count
  function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    r = v;
    unique case (n)
      4'd0:    r = '0;
      4'd1:    r = {{56{v[7]}},  v[7:0]};
      4'd2:    r = {{48{v[15]}}, v[15:0]};
      4'd3:    r = {{40{v[23]}}, v[23:0]};
      4'd4:    r = {{32{v[31]}}, v[31:0]};
      4'd5:    r = {{24{v[39]}}, v[39:0]};
      4'd6:    r = {{16{v[47]}}, v[47:0]};
      4'd7:    r = {{8{v[55]}},  v[55:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && !q_full;
  assign b            = in_ch.run_byte;
  assign lo           = 4'(b & red_pkg::LEN_NIBBLE_MASK);
  assign hi           = 4'((b & red_pkg::OFF_NIBBLE_MASK) >> 4);
  assign pos_inc      = pos_r + 4'd1;
  assign byte_shifted = 64'(b) << {pos_r[2:0], 3'b000};

  always_comb begin
    phase_nxt     = phase_r;
    len_bytes_nxt = len_bytes_r;
    off_bytes_nxt = off_bytes_r;
    pos_nxt       = pos_r;
    len_acc_nxt   = len_acc_r;
    off_acc_nxt   = off_acc_r;
    push          = '0;
    if (accept) begin
      unique case (phase_r)
        PH_LEN: begin
          len_acc_nxt = len_acc_r | byte_shifted;
          pos_nxt     = pos_inc;
          if (pos_inc >= len_bytes_r) begin
            pos_nxt = '0;
            if (off_bytes_r == 4'd0) begin
              phase_nxt         = PH_HDR;
              push.valid        = 1'b1;
              push.req.kind     = red_pkg::KIND_RUN;
              push.req.count    = len_acc_nxt;
              push.req.offset   = '0;
            end else begin
              phase_nxt = PH_OFF;
            end
          end
        end
        PH_OFF: begin
          off_acc_nxt = off_acc_r | byte_shifted;
          pos_nxt     = pos_inc;
          if (pos_inc >= off_bytes_r) begin
            pos_nxt         = '0;
            phase_nxt       = PH_HDR;
            push.valid      = 1'b1;
            push.req.kind   = red_pkg::KIND_RUN;
            push.req.count  = len_acc_r;
            push.req.offset = sext(off_acc_nxt, off_bytes_r);
          end
        end
        default: begin
          // header byte; the unused phase code lands here too
          phase_nxt = PH_HDR;
          if (b == 8'd0) begin
            push.valid    = 1'b1;
            push.req.kind = red_pkg::KIND_END;
          end else if (lo > red_pkg::MAX_FIELD_BYTES || hi > red_pkg::MAX_FIELD_BYTES) begin
            push.valid    = 1'b1;
            push.req.kind = red_pkg::KIND_BAD;
          end else begin
            len_bytes_nxt = lo;
            off_bytes_nxt = hi;
            pos_nxt       = '0;
            len_acc_nxt   = '0;
            off_acc_nxt   = '0;
            phase_nxt     = (lo != 4'd0) ? PH_LEN : PH_OFF;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      len_bytes_r <= '0;
      off_bytes_r <= '0;
      pos_r       <= '0;
      len_acc_r   <= '0;
      off_acc_r   <= '0;
    end else begin
      phase_r     <= phase_nxt;
      len_bytes_r <= len_bytes_nxt;
      off_bytes_r <= off_bytes_nxt;
      pos_r       <= pos_nxt;
      len_acc_r   <= len_acc_nxt;
      off_acc_r   <= off_acc_nxt;
    end
  end

endmodule

[sv/red_queue.sv]
module red_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  red_pkg::red_push_t push,
  output logic               full,
  output logic               q_valid,
  output red_pkg::red_req_t  q_data,
  input  logic               pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  red_pkg::red_req_t mem [DEPTH];

  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem[rd_ptr_r];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[sv/red_back.sv]
module red_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  red_pkg::red_req_t q_data,
  output logic              pop,
  input  logic [47:0]       part_start,
  input  logic [7:0]        sec_per_clu,
  red_result_if.source      out_ch
);

  // running sums
  logic [63:0] cur_r, cur_nxt;
  logic [63:0] virt_r, virt_nxt;

  // cluster stage
  logic        a_v_r;
  logic [1:0]  a_kind_r;
  logic [63:0] a_start_r, a_count_r, a_virt_r;

  // sector / output stage
  logic        b_v_r;
  logic [63:0] b_start_r, b_count_r, b_virt_r, b_sector_r;
  logic        b_end_r, b_bad_r;

  logic        a_load, b_load, a_is_run;
  logic [63:0] run_start;
  logic [71:0] prod;

  assign b_load    = !b_v_r || out_ch.ready;
  assign a_load    = !a_v_r || b_load;
  assign pop       = q_valid && a_load;
  assign run_start = cur_r + q_data.offset;
  assign a_is_run  = (a_kind_r == red_pkg::KIND_RUN);
  assign prod      = a_start_r * sec_per_clu;

  always_comb begin
    cur_nxt  = cur_r;
    virt_nxt = virt_r;
    if (pop) begin
      if (q_data.kind == red_pkg::KIND_RUN) begin
        cur_nxt  = run_start;
        virt_nxt = virt_r + q_data.count;
      end else if (q_data.kind == red_pkg::KIND_END) begin
        cur_nxt  = '0;
        virt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      virt_r <= '0;
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
    end else begin
      cur_r  <= cur_nxt;
      virt_r <= virt_nxt;
      if (a_load) begin
        a_v_r <= pop;
      end
      if (b_load) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_kind_r <= q_data.kind;
      if (q_data.kind == red_pkg::KIND_RUN) begin
        a_start_r <= run_start;
        a_count_r <= q_data.count;
        a_virt_r  <= virt_r;
      end else begin
        a_start_r <= '0;
        a_count_r <= '0;
        a_virt_r  <= '0;
      end
    end
    if (b_load && a_v_r) begin
      b_start_r  <= a_start_r;
      b_count_r  <= a_count_r;
      b_virt_r   <= a_virt_r;
      b_sector_r <= a_is_run ? prod[63:0] + {16'd0, part_start} : '0;
      b_end_r    <= (a_kind_r == red_pkg::KIND_END);
      b_bad_r    <= (a_kind_r == red_pkg::KIND_BAD);
    end
  end

  assign out_ch.valid             = b_v_r;
  assign out_ch.run_start_cluster = b_start_r;
  assign out_ch.run_cluster_count = b_count_r;
  assign out_ch.run_first_virtual = b_virt_r;
  assign out_ch.run_first_sector  = b_sector_r;
  assign out_ch.list_end          = b_end_r;
  assign out_ch.bad_header        = b_bad_r;

endmodule
